FILE: src/hapc_pkg.sv
// ----------------------------------------------------------------------------
// hapc_pkg
// Shared types and constants of the heading alignment controller: register
// indexes, field widths and the configuration register set.
// ----------------------------------------------------------------------------
package hapc_pkg;

  localparam int RATE_W   = 16;
  localparam int TARGET_W = 17;
  localparam int SCALE_W  = 16;
  localparam int BYTE_W   = 8;
  localparam int TOL_W    = 16;
  localparam int ERROR_W  = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int SCALE_SHIFT = 16;
  localparam int GAIN_SHIFT  = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_MIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_MAX = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd5;

  localparam logic [TARGET_W-1:0] RST_TARGET    = 17'd0;
  localparam logic [SCALE_W-1:0]  RST_STEP      = 16'd655;
  localparam logic [BYTE_W-1:0]   RST_GAIN      = 8'd24;
  localparam logic [BYTE_W-1:0]   RST_SPEED_MIN = 8'd50;
  localparam logic [BYTE_W-1:0]   RST_SPEED_MAX = 8'd255;
  localparam logic [TOL_W-1:0]    RST_TOLERANCE = 16'd512;

  typedef struct packed {
    logic [TARGET_W-1:0] target_heading;
    logic [SCALE_W-1:0]  step_scale;
    logic [BYTE_W-1:0]   gain;
    logic [BYTE_W-1:0]   speed_min;
    logic [BYTE_W-1:0]   speed_max;
    logic [TOL_W-1:0]    tolerance;
  } cfg_t;

endpackage

FILE: src/hapc_front.sv
// ----------------------------------------------------------------------------
// hapc_front
// Accepts rate samples and turns each into a heading increment, the sample
// times the timestep scale floored to whole heading units.
// ----------------------------------------------------------------------------
module hapc_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [hapc_pkg::RATE_W-1:0]    in_rate_sample,
  input  logic [hapc_pkg::SCALE_W-1:0]          step_scale,
  output logic                                  push_valid,
  input  logic                                  push_ready,
  output logic signed [hapc_pkg::RATE_W-1:0]    push_delta
);

  localparam int PROD_W = hapc_pkg::RATE_W + hapc_pkg::SCALE_W + 1;

  logic                                valid_r;
  logic signed [hapc_pkg::RATE_W-1:0]  rate_r;
  logic signed [PROD_W-1:0]            prod;
  logic signed [hapc_pkg::SCALE_W:0]   scale_s;

  assign scale_s    = $signed({1'b0, step_scale});
  assign prod       = rate_r * scale_s;
  assign push_valid = valid_r;
  assign push_delta = prod[hapc_pkg::SCALE_SHIFT +: hapc_pkg::RATE_W];
  assign in_ready   = !valid_r || push_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rate_r <= in_rate_sample;
    end
  end

endmodule

FILE: src/hapc_queue.sv
// ----------------------------------------------------------------------------
// hapc_queue
// Short queue of heading increments between the front and the back.
// ----------------------------------------------------------------------------
module hapc_queue (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  push_valid,
  output logic                                  push_ready,
  input  logic signed [hapc_pkg::RATE_W-1:0]    push_delta,
  output logic                                  pop_valid,
  input  logic                                  pop_ready,
  output logic signed [hapc_pkg::RATE_W-1:0]    pop_delta
);

  localparam int PTR_W = $clog2(hapc_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(hapc_pkg::QUEUE_DEPTH + 1);

  logic signed [hapc_pkg::RATE_W-1:0] mem_r [hapc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_W'(hapc_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_delta  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(hapc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(hapc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_delta;
    end
  end

endmodule

FILE: src/hapc_back.sv
// ----------------------------------------------------------------------------
// hapc_back
// Integrates increments into the heading, wraps it, folds the error and
// derives the clamped drive speed, holding each result in an output register.
// ----------------------------------------------------------------------------
module hapc_back #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  hapc_pkg::cfg_t                        cfg,
  input  logic                                  pop_valid,
  output logic                                  pop_ready,
  input  logic signed [hapc_pkg::RATE_W-1:0]    pop_delta,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [hapc_pkg::BYTE_W-1:0]           out_drive_speed,
  output logic                                  out_turn_clockwise,
  output logic                                  out_aligned,
  output logic signed [hapc_pkg::ERROR_W-1:0]   out_heading_error
);

  localparam int FULL = 360 << FRAC_BITS;
  localparam int HALF = 180 << FRAC_BITS;
  localparam int HW   = $clog2(FULL);
  localparam int HSW  = ((HW > hapc_pkg::RATE_W) ? HW : hapc_pkg::RATE_W) + 2;
  localparam int ERW  = ((HW > hapc_pkg::TARGET_W) ? HW : hapc_pkg::TARGET_W) + 2;
  localparam int MW   = ERW - 1;
  localparam int PW   = MW + hapc_pkg::BYTE_W;
  localparam int SH   = FRAC_BITS + hapc_pkg::GAIN_SHIFT;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WRAP = 5'b00010,
    S_ERR  = 5'b00100,
    S_MAG  = 5'b01000,
    S_SPD  = 5'b10000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [HW-1:0]            heading_r, heading_nxt;
  logic signed [HSW-1:0]    h_r, h_nxt;
  logic signed [ERW-1:0]    err_r, err_nxt;
  logic [MW-1:0]            mag_r, mag_nxt;
  logic signed [ERW-1:0]    diff;
  logic [PW-1:0]            prod;
  logic [PW-1:0]            speed_full;
  logic [hapc_pkg::BYTE_W-1:0] speed;
  logic                     done;
  logic                     out_free;
  logic                     out_load;
  logic                     out_valid_r;
  logic [hapc_pkg::BYTE_W-1:0]         speed_r;
  logic                                turn_r;
  logic                                aligned_r;
  logic signed [hapc_pkg::ERROR_W-1:0] herr_r;

  assign out_free  = !out_valid_r || out_ready;
  assign pop_ready = (state_r == S_IDLE);

  assign diff = $signed(ERW'(cfg.target_heading)) - $signed(ERW'(heading_r));
  assign prod = PW'(mag_r) * PW'(cfg.gain);
  assign speed_full = prod >> SH;
  assign done = (mag_r <= MW'(cfg.tolerance));

  always_comb begin
    if (speed_full < PW'(cfg.speed_min)) begin
      speed = cfg.speed_min;
    end else if (speed_full > PW'(cfg.speed_max)) begin
      speed = cfg.speed_max;
    end else begin
      speed = speed_full[hapc_pkg::BYTE_W-1:0];
    end
  end

  always_comb begin
    state_nxt   = state_r;
    heading_nxt = heading_r;
    h_nxt       = h_r;
    err_nxt     = err_r;
    mag_nxt     = mag_r;
    out_load    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          h_nxt     = $signed(HSW'(heading_r)) + HSW'(pop_delta);
          state_nxt = S_WRAP;
        end
      end
      S_WRAP: begin
        if (h_r < 0) begin
          h_nxt = h_r + HSW'(FULL);
        end else if (h_r >= HSW'(FULL)) begin
          h_nxt = h_r - HSW'(FULL);
        end else begin
          heading_nxt = h_r[HW-1:0];
          state_nxt   = S_ERR;
        end
      end
      S_ERR: begin
        if (diff > ERW'(HALF)) begin
          err_nxt = diff - ERW'(FULL);
        end else if (diff < -ERW'(HALF)) begin
          err_nxt = diff + ERW'(FULL);
        end else begin
          err_nxt = diff;
        end
        state_nxt = S_MAG;
      end
      S_MAG: begin
        mag_nxt   = err_r[ERW-1] ? MW'(-err_r) : MW'(err_r);
        state_nxt = S_SPD;
      end
      S_SPD: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      heading_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      heading_r <= heading_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    h_r   <= h_nxt;
    err_r <= err_nxt;
    mag_r <= mag_nxt;
    if (out_load) begin
      speed_r   <= done ? '0 : speed;
      turn_r    <= !err_r[ERW-1] && (err_r != '0);
      aligned_r <= done;
      herr_r    <= err_r[hapc_pkg::ERROR_W-1:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_drive_speed    = speed_r;
  assign out_turn_clockwise = turn_r;
  assign out_aligned        = aligned_r;
  assign out_heading_error  = herr_r;

endmodule

FILE: src/heading_align_p_controller.sv
// ----------------------------------------------------------------------------
// heading_align_p_controller
// Proportional heading alignment controller with angle wrap.
// ----------------------------------------------------------------------------
// Each request carries one yaw-rate sample and produces one result. The front
// registers the sample and scales it into a heading increment, which then
// enters a two-entry queue. The back sequencer pops the increment, updates and
// wraps the heading, folds the error, takes its magnitude and loads the result
// register, in that order. Every 360 degree wrap of the heading adds a pass
// through the wrap step, and more than one wrap per sample occurs only for
// FRAC_BITS below 7. The back takes a new increment only after it has loaded
// the result of the last one, and a result that is not taken holds the back
// in its last step.
module heading_align_p_controller #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [hapc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [hapc_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [hapc_pkg::RATE_W-1:0]    in_rate_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [hapc_pkg::BYTE_W-1:0]           out_drive_speed,
  output logic                                  out_turn_clockwise,
  output logic                                  out_aligned,
  output logic signed [hapc_pkg::ERROR_W-1:0]   out_heading_error
);

  hapc_pkg::cfg_t cfg_r;
  logic                               push_valid;
  logic                               push_ready;
  logic signed [hapc_pkg::RATE_W-1:0] push_delta;
  logic                               pop_valid;
  logic                               pop_ready;
  logic signed [hapc_pkg::RATE_W-1:0] pop_delta;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_heading <= hapc_pkg::RST_TARGET;
      cfg_r.step_scale     <= hapc_pkg::RST_STEP;
      cfg_r.gain           <= hapc_pkg::RST_GAIN;
      cfg_r.speed_min      <= hapc_pkg::RST_SPEED_MIN;
      cfg_r.speed_max      <= hapc_pkg::RST_SPEED_MAX;
      cfg_r.tolerance      <= hapc_pkg::RST_TOLERANCE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hapc_pkg::REG_TARGET: begin
          cfg_r.target_heading <= cfg_data[hapc_pkg::TARGET_W-1:0];
        end
        hapc_pkg::REG_STEP: begin
          cfg_r.step_scale <= cfg_data[hapc_pkg::SCALE_W-1:0];
        end
        hapc_pkg::REG_GAIN: begin
          cfg_r.gain <= cfg_data[hapc_pkg::BYTE_W-1:0];
        end
        hapc_pkg::REG_SPEED_MIN: begin
          cfg_r.speed_min <= cfg_data[hapc_pkg::BYTE_W-1:0];
        end
        hapc_pkg::REG_SPEED_MAX: begin
          cfg_r.speed_max <= cfg_data[hapc_pkg::BYTE_W-1:0];
        end
        hapc_pkg::REG_TOLERANCE: begin
          cfg_r.tolerance <= cfg_data[hapc_pkg::TOL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  hapc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rate_sample (in_rate_sample),
    .step_scale     (cfg_r.step_scale),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_delta     (push_delta)
  );

  hapc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_delta (push_delta),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_delta  (pop_delta)
  );

  hapc_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .pop_valid          (pop_valid),
    .pop_ready          (pop_ready),
    .pop_delta          (pop_delta),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_drive_speed    (out_drive_speed),
    .out_turn_clockwise (out_turn_clockwise),
    .out_aligned        (out_aligned),
    .out_heading_error  (out_heading_error)
  );

endmodule
